FILE: hw/rtl/acrp_pkg.sv
// Shared types and constants for the ATM cell rate policer.
package acrp_pkg;

   // Fixed-point layout of level, limit and increment
   localparam int FRAC_BITS  = 16;
   localparam int LEVEL_W    = 40;
   localparam int INCR_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int TNOW_W     = 32;
   localparam int VCI_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_MODE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_VCI    = 3'd4;

   // Input operation codes
   typedef enum logic {
      OP_CELL       = 1'b0,
      OP_TIME_RESET = 1'b1
   } op_type;

   // Result action codes
   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_PASS    = 2'd1,
      ACT_TAG     = 2'd2,
      ACT_DISCARD = 2'd3
   } action_type;

   typedef struct packed {
      logic [INCR_W-1:0]  increment;
      logic [LEVEL_W-1:0] limit;
      logic               tag_mode;
      logic               filter_enable;
      logic [VCI_W-1:0]   filter_vci;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic [TNOW_W-1:0] time_now;
      logic [VCI_W-1:0]  cell_vci;
      logic              cell_clp;
   } item_type;

   typedef struct packed {
      action_type         action;
      logic               clp_out;
      logic [LEVEL_W-1:0] level_out;
      logic [COUNT_W-1:0] violations;
      logic               count_saturated;
   } result_type;

endpackage

FILE: hw/rtl/atm_cell_rate_policer.sv
// Top level of the ATM cell rate policer: stream ports, stage registers.
//
// ATM cell rate policer (continuous-state leaky bucket). One beat in gives
// one beat out, in order. A beat is taken every cycle while the result side
// keeps up; each beat is held in the input register, then the bucket update
// writes its result into the result register. The bucket level, last arrival
// time and violation counter are updated together, which allows a
// rate of one beat per cycle while the result side keeps up. Configuration
// writes are always accepted and must only be made while no beat is in flight.
module atm_cell_rate_policer
   import acrp_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: time_now[31:0], cell_vci[47:32], cell_clp[48], zero pad [55:49]
   input  logic [55:0]           req_tdata,
   // tuser: op
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: clp_out[0], level_out[40:1], violations[72:41],
   //        count_saturated[73], zero pad [79:74]
   output logic [79:0]           rsp_tdata,
   // tuser: action
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   in_ff, in_in;
   logic       in_valid_ff, in_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;

   acrp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   acrp_core #(.TIME_WIDTH(TIME_WIDTH)) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_ff),
      .result (result)
   );

   // Handshake: the held beat moves on when the result slot is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input stage
   always_comb begin
      in_in.op       = op_type'(req_tuser);
      in_in.time_now = req_tdata[31:0];
      in_in.cell_vci = req_tdata[47:32];
      in_in.cell_clp = req_tdata[48];
      in_valid_in    = req_tvalid || (in_valid_ff && !advance);
   end

   // Result stage
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_ff  <= in_in;
      if (advance)                  rsp_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tdata  = {6'd0, rsp_ff.count_saturated, rsp_ff.violations,
                        rsp_ff.level_out, rsp_ff.clp_out};

endmodule

FILE: hw/rtl/acrp_csr.sv
// Configuration register bank of the policer.
module acrp_csr
   import acrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INCREMENT:     cfg_in.increment     = csr_wdata[INCR_W-1:0];
            CSR_LIMIT:         cfg_in.limit         = csr_wdata[LEVEL_W-1:0];
            CSR_TAG_MODE:      cfg_in.tag_mode      = csr_wdata[0];
            CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_wdata[0];
            CSR_FILTER_VCI:    cfg_in.filter_vci    = csr_wdata[VCI_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.increment     <= INCR_W'(1) << FRAC_BITS;
         cfg_ff.limit         <= LEVEL_W'(1) << FRAC_BITS;
         cfg_ff.tag_mode      <= 1'b1;
         cfg_ff.filter_enable <= 1'b0;
         cfg_ff.filter_vci    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/acrp_core.sv
// Bucket state registers and the combinational policing update.
module acrp_core
   import acrp_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   localparam int CMP_W = (TIME_WIDTH > LEVEL_W) ? TIME_WIDTH : LEVEL_W;

   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] elapsed;
   logic [CMP_W-1:0]      elapsed_c;
   logic [CMP_W-1:0]      level_int;
   logic [LEVEL_W-1:0]    drained;
   logic [LEVEL_W:0]      sum;
   logic                  policed;
   logic                  violate;

   // Drain: one unit per elapsed slot, clamped at zero
   assign now_t     = TIME_WIDTH'(item.time_now);
   assign elapsed   = now_t - last_ff;
   assign elapsed_c = CMP_W'(elapsed);
   assign level_int = CMP_W'(level_ff >> FRAC_BITS);
   assign drained   = (elapsed_c > level_int) ? '0
                    : level_ff - LEVEL_W'(elapsed_c << FRAC_BITS);

   // Judge and add with saturation
   assign policed = (item.op == OP_CELL) && !item.cell_clp &&
                    (!cfg.filter_enable || (item.cell_vci == cfg.filter_vci));
   assign violate = drained > cfg.limit;
   assign sum     = {1'b0, drained} + (LEVEL_W+1)'(cfg.increment);

   always_comb begin
      level_in       = level_ff;
      last_in        = last_ff;
      count_in       = count_ff;
      result.action  = ACT_PASS;
      result.clp_out = item.cell_clp;
      if (item.op == OP_TIME_RESET) begin
         level_in       = drained;
         last_in        = '0;
         result.action  = ACT_NONE;
         result.clp_out = 1'b0;
      end else if (policed) begin
         last_in = now_t;
         if (violate) begin
            level_in = drained;
            if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_W'(1);
            if (cfg.tag_mode) begin
               result.action  = ACT_TAG;
               result.clp_out = 1'b1;
            end else begin
               result.action  = ACT_DISCARD;
               result.clp_out = 1'b0;
            end
         end else begin
            level_in       = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
            result.clp_out = 1'b0;
         end
      end
      result.level_out       = level_in;
      result.violations      = count_in;
      result.count_saturated = (count_in == COUNT_MAX);
   end

   // State only moves on a step
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         last_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         level_ff <= level_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(count_ff) && $stable(level_ff) && $stable(last_ff))
      else $error("policer state moved without a step");

   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      step |=> count_ff >= $past(count_ff))
      else $error("violation count went backwards");

   a_time_reset: assert property (@(posedge clock) disable iff (reset)
      step && item.op == OP_TIME_RESET |=> last_ff == '0)
      else $error("time base reset left last arrival set");

   a_pass_keeps: assert property (@(posedge clock) disable iff (reset)
      step && item.op == OP_CELL && !policed |=> $stable(level_ff))
      else $error("unpoliced cell changed the bucket");
`endif

endmodule
